>>> rtl/lisp_token_scanner_macros.svh
// ---------------------------------------------------------------------------
// lisp_token_scanner_macros: assertion macros
// Shared concurrent assertion forms for the token scanner.
// ---------------------------------------------------------------------------
`ifndef LISP_TOKEN_SCANNER_MACROS_SVH
`define LISP_TOKEN_SCANNER_MACROS_SVH

// same-cycle implication
`define LTS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lisp_token_scanner: assertion failed");

// next-cycle implication
`define LTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lisp_token_scanner: assertion failed");

`endif

>>> rtl/lts_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lts_pkg
// Token kinds, scan modes, character codes and the token queue entry.
// ---------------------------------------------------------------------------
package lts_pkg;

   localparam int POS_WIDTH_DEFAULT   = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int POS_OUT_W           = 16;
   localparam int KIND_W              = 4;
   localparam int MODE_W              = 4;

   localparam logic [KIND_W-1:0] K_END     = 4'd0;
   localparam logic [KIND_W-1:0] K_LPAREN  = 4'd1;
   localparam logic [KIND_W-1:0] K_RPAREN  = 4'd2;
   localparam logic [KIND_W-1:0] K_DOT     = 4'd3;
   localparam logic [KIND_W-1:0] K_PATH    = 4'd4;
   localparam logic [KIND_W-1:0] K_QLPAREN = 4'd5;
   localparam logic [KIND_W-1:0] K_QSYM    = 4'd6;
   localparam logic [KIND_W-1:0] K_STRING  = 4'd7;
   localparam logic [KIND_W-1:0] K_INT     = 4'd8;
   localparam logic [KIND_W-1:0] K_SYMBOL  = 4'd9;
   localparam logic [KIND_W-1:0] K_ERROR   = 4'd10;

   localparam logic [MODE_W-1:0] M_IDLE    = 4'd0;
   localparam logic [MODE_W-1:0] M_COMMENT = 4'd1;
   localparam logic [MODE_W-1:0] M_DOT     = 4'd2;
   localparam logic [MODE_W-1:0] M_PATH    = 4'd3;
   localparam logic [MODE_W-1:0] M_QUOTE   = 4'd4;
   localparam logic [MODE_W-1:0] M_QSYM    = 4'd5;
   localparam logic [MODE_W-1:0] M_STRING  = 4'd6;
   localparam logic [MODE_W-1:0] M_INT     = 4'd7;
   localparam logic [MODE_W-1:0] M_SYMBOL  = 4'd8;

   localparam logic [7:0] CH_EOT    = 8'h00;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_TILDE  = 8'h7E;

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [POS_OUT_W-1:0] start_pos;
      logic [POS_OUT_W-1:0] end_pos;
   } token_type;

   // one beat of the token queue: all tokens caused by one byte
   typedef struct packed {
      logic      pair;
      token_type tok0;
      token_type tok1;
   } entry_type;

   function automatic logic is_num(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_sym(input logic [7:0] c);
      logic excl;
      excl = (c == CH_DQUOTE) || (c == CH_QUOTE) || (c == CH_DOT) ||
             (c == CH_LPAREN) || (c == CH_RPAREN);
      return !excl && (c > CH_SPACE) && (c <= CH_TILDE);
   endfunction

   function automatic logic is_sym_start(input logic [7:0] c);
      return !is_num(c) && is_sym(c);
   endfunction

endpackage

>>> rtl/lts_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lts_front: scan front end
// Takes one byte per beat while the queue is not full, tracks the scan mode
// and builds the queue entry holding the tokens that byte completes.
// ---------------------------------------------------------------------------
module lts_front #(
   parameter int POS_WIDTH = lts_pkg::POS_WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  logic [7:0]          req_text_byte,
   input  logic                q_full,
   output logic                q_push,
   output lts_pkg::entry_type  q_data
);
   import lts_pkg::*;

   localparam int EXT_W = (POS_WIDTH > POS_OUT_W) ? POS_WIDTH : POS_OUT_W;

   function automatic logic [POS_OUT_W-1:0] out_pos(input logic [POS_WIDTH-1:0] v);
      logic [EXT_W-1:0] w;
      w = EXT_W'(v);
      return w[POS_OUT_W-1:0];
   endfunction

   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [POS_WIDTH-1:0] start_ff, start_in;
   logic [POS_WIDTH-1:0] pos_ff, pos_in;

   logic                 accept;
   logic [7:0]           c;
   logic [POS_WIDTH-1:0] p1, s1;

   logic                 prim_emit;
   logic [KIND_W-1:0]    prim_kind;
   logic [POS_WIDTH-1:0] prim_e;
   logic                 do_fresh;
   logic [MODE_W-1:0]    nxt_mode;
   logic [POS_WIDTH-1:0] nxt_start;

   logic                 f_emit;
   logic [KIND_W-1:0]    f_kind;
   logic [POS_WIDTH-1:0] f_e;
   logic [MODE_W-1:0]    f_mode;

   token_type            prim_tok, fresh_tok;

   assign accept = req_push && !q_full;
   assign c      = req_text_byte;
   assign p1     = pos_ff + 1'b1;
   assign s1     = start_ff + 1'b1;

   // byte handled from idle
   always_comb begin
      f_emit = 1'b0;
      f_kind = K_END;
      f_e    = p1;
      f_mode = M_IDLE;
      priority if (c == CH_EOT) begin
         f_emit = 1'b1;
         f_kind = K_END;
         f_e    = pos_ff;
      end else if (c == CH_SEMI) begin
         f_mode = M_COMMENT;
      end else if (c == CH_LPAREN) begin
         f_emit = 1'b1;
         f_kind = K_LPAREN;
      end else if (c == CH_RPAREN) begin
         f_emit = 1'b1;
         f_kind = K_RPAREN;
      end else if (c == CH_DOT) begin
         f_mode = M_DOT;
      end else if (c == CH_QUOTE) begin
         f_mode = M_QUOTE;
      end else if ((c == CH_SPACE) || (c == CH_NL)) begin
         f_mode = M_IDLE;
      end else if (c == CH_DQUOTE) begin
         f_mode = M_STRING;
      end else if (is_num(c)) begin
         f_mode = M_INT;
      end else if (is_sym_start(c)) begin
         f_mode = M_SYMBOL;
      end else begin
         f_emit = 1'b1;
         f_kind = K_ERROR;
      end
   end

   // token pending in the current mode
   always_comb begin
      prim_emit = 1'b0;
      prim_kind = K_END;
      prim_e    = pos_ff;
      do_fresh  = 1'b0;
      nxt_mode  = M_IDLE;
      nxt_start = start_ff;
      unique case (mode_ff)
         M_COMMENT: begin
            if (c == CH_NL) begin
               nxt_mode = M_IDLE;
            end else if (c == CH_EOT) begin
               prim_emit = 1'b1;
               prim_kind = K_ERROR;
               do_fresh  = 1'b1;
            end else begin
               nxt_mode = M_COMMENT;
            end
         end
         M_DOT: begin
            if (c == CH_SLASH) begin
               nxt_mode = M_PATH;
            end else begin
               prim_emit = 1'b1;
               prim_kind = K_DOT;
               prim_e    = s1;
               do_fresh  = 1'b1;
            end
         end
         M_PATH: begin
            if (is_sym(c) || (c == CH_DOT)) begin
               nxt_mode = M_PATH;
            end else begin
               prim_emit = 1'b1;
               prim_kind = K_PATH;
               do_fresh  = 1'b1;
            end
         end
         M_QUOTE: begin
            if (c == CH_LPAREN) begin
               prim_emit = 1'b1;
               prim_kind = K_QLPAREN;
               prim_e    = p1;
            end else if (is_sym_start(c)) begin
               nxt_mode  = M_QSYM;
               nxt_start = pos_ff;
            end else begin
               prim_emit = 1'b1;
               prim_kind = K_ERROR;
               prim_e    = s1;
               do_fresh  = 1'b1;
            end
         end
         M_QSYM, M_SYMBOL: begin
            if (is_sym(c)) begin
               nxt_mode = mode_ff;
            end else begin
               prim_emit = 1'b1;
               prim_kind = (mode_ff == M_QSYM) ? K_QSYM : K_SYMBOL;
               do_fresh  = 1'b1;
            end
         end
         M_INT: begin
            if (is_num(c)) begin
               nxt_mode = M_INT;
            end else begin
               prim_emit = 1'b1;
               prim_kind = K_INT;
               do_fresh  = 1'b1;
            end
         end
         M_STRING: begin
            if (c == CH_DQUOTE) begin
               prim_emit = 1'b1;
               prim_kind = K_STRING;
               prim_e    = p1;
            end else if (c == CH_EOT) begin
               prim_emit = 1'b1;
               prim_kind = K_ERROR;
               do_fresh  = 1'b1;
            end else begin
               nxt_mode = M_STRING;
            end
         end
         default: begin
            do_fresh = 1'b1;
         end
      endcase
      if (do_fresh) begin
         nxt_mode  = f_mode;
         nxt_start = pos_ff;
      end
   end

   always_comb begin
      prim_tok.kind       = prim_kind;
      prim_tok.start_pos  = out_pos(start_ff);
      prim_tok.end_pos    = out_pos(prim_e);
      fresh_tok.kind      = f_kind;
      fresh_tok.start_pos = out_pos(pos_ff);
      fresh_tok.end_pos   = out_pos(f_e);

      q_data.pair = prim_emit && do_fresh && f_emit;
      q_data.tok0 = prim_emit ? prim_tok : fresh_tok;
      q_data.tok1 = fresh_tok;
      q_push      = accept && (prim_emit || (do_fresh && f_emit));
   end

   always_comb begin
      mode_in  = mode_ff;
      start_in = start_ff;
      pos_in   = pos_ff;
      if (accept) begin
         if (c == CH_EOT) begin
            mode_in  = M_IDLE;
            start_in = '0;
            pos_in   = '0;
         end else begin
            mode_in  = nxt_mode;
            start_in = nxt_start;
            pos_in   = p1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         start_ff <= '0;
         pos_ff   <= '0;
      end else begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

>>> rtl/lts_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lts_queue: token queue
// Small register queue of per-byte token entries between front and back.
// ---------------------------------------------------------------------------
module lts_queue #(
   parameter int DEPTH = lts_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lts_pkg::entry_type wr_data,
   output logic               full,
   input  logic               pop,
   output logic               valid,
   output lts_pkg::entry_type rd_data
);
   import lts_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign valid   = (count_ff != '0);
   assign rd_data = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> rtl/lts_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lts_back: result back end
// Splits each queue entry into single tokens and holds the current one in
// the result register until it is popped.
// ---------------------------------------------------------------------------
module lts_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  lts_pkg::entry_type               q_data,
   output logic                             q_pop,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [lts_pkg::KIND_W-1:0]       rsp_token_kind,
   output logic [lts_pkg::POS_OUT_W-1:0]    rsp_start_pos,
   output logic [lts_pkg::POS_OUT_W-1:0]    rsp_end_pos,
   output logic                             rsp_last_of_run
);
   import lts_pkg::*;

   logic      valid_ff, valid_in;
   logic      half_ff, half_in;
   token_type tok_ff, sel_tok;
   logic      last_ff, sel_last;
   logic      load;

   assign load     = q_valid && (!valid_ff || rsp_pop);
   assign sel_tok  = half_ff ? q_data.tok1 : q_data.tok0;
   assign sel_last = half_ff || !q_data.pair;
   assign q_pop    = load && sel_last;

   always_comb begin
      valid_in = valid_ff;
      half_in  = half_ff;
      if (load) begin
         valid_in = 1'b1;
         half_in  = !sel_last;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tok_ff  <= sel_tok;
         last_ff <= sel_last;
      end
   end

   assign rsp_empty       = !valid_ff;
   assign rsp_token_kind  = tok_ff.kind;
   assign rsp_start_pos   = tok_ff.start_pos;
   assign rsp_end_pos     = tok_ff.end_pos;
   assign rsp_last_of_run = last_ff;

endmodule

>>> rtl/lisp_token_scanner.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lisp_token_scanner
// Streaming S-expression lexer: bytes in, tokens with byte offsets out.
// ---------------------------------------------------------------------------
// Push one source byte per cycle; a zero byte ends the text, emits the end
// token and resets the offset. The front end classifies each byte and queues
// the one or two tokens it completes, if any, as one entry; the back end
// delivers one token per cycle while results are popped, so a byte that both
// closes and opens a token yields two tokens in turn. A token passes through
// the entry queue and then the result register to the result ports. The
// entry queue (QUEUE_DEPTH entries) decides how many bytes are taken while
// the result side stalls; full rises once it is filled.
`include "lisp_token_scanner_macros.svh"

module lisp_token_scanner #(
   parameter int POS_WIDTH   = lts_pkg::POS_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH = lts_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [7:0]                    req_text_byte,
   output logic                          empty,
   input  logic                          pop,
   output logic [lts_pkg::KIND_W-1:0]    rsp_token_kind,
   output logic [lts_pkg::POS_OUT_W-1:0] rsp_start_pos,
   output logic [lts_pkg::POS_OUT_W-1:0] rsp_end_pos,
   output logic                          rsp_last_of_run
);
   import lts_pkg::*;

   logic              q_push, q_full, q_pop, q_valid;
   entry_type         q_wr_data, q_rd_data;
   logic              eot_beat;
   logic [KIND_W-1:0] eot_last_kind;

   assign full = q_full;

   lts_front #(
      .POS_WIDTH (POS_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (push),
      .req_text_byte (req_text_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_data        (q_wr_data)
   );

   lts_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_data),
      .full    (q_full),
      .pop     (q_pop),
      .valid   (q_valid),
      .rd_data (q_rd_data)
   );

   lts_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_data          (q_rd_data),
      .q_pop           (q_pop),
      .rsp_empty       (empty),
      .rsp_pop         (pop),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_start_pos   (rsp_start_pos),
      .rsp_end_pos     (rsp_end_pos),
      .rsp_last_of_run (rsp_last_of_run)
   );

   assign eot_beat      = push && !full && (req_text_byte == CH_EOT);
   assign eot_last_kind = q_wr_data.pair ? q_wr_data.tok1.kind : q_wr_data.tok0.kind;

   // end of text always queues an entry whose final token is the end token
   `LTS_ASSERT_NOW(a_eot_pushes, clock, reset, eot_beat, q_push)
   `LTS_ASSERT_NOW(a_eot_last_end, clock, reset, eot_beat, eot_last_kind == K_END)
   // nothing queued and nothing held: results stay empty
   `LTS_ASSERT_NEXT(a_no_phantom, clock, reset, !q_valid && empty && !q_push, empty)

endmodule
